// File: src/alvs_pkg.sv
// Package for the acceleration-limited velocity smoother.
// Holds widths, register indexes and controller command types; no dependencies.
`default_nettype none
package alvs_pkg;
  localparam int VW = 32;
  localparam int FB = 16;
  localparam int DW = VW + 1;
  localparam int SW = 2 * VW + 2;
  localparam int LW = 31;
  localparam int RW = VW + 1;

  localparam logic [1:0] REG_MAX_LIN = 2'd0;
  localparam logic [1:0] REG_MAX_ANG = 2'd1;
  localparam logic [1:0] REG_BLEND = 2'd2;
  localparam logic [1:0] REG_PERIOD = 2'd3;

  typedef struct packed {
    logic       load;
    logic       vec_sel;
    logic       diff;
    logic       sq_start;
    logic       lim_mul;
    logic       root_start;
    logic       root_step;
    logic       div_start;
    logic       div_step;
    logic       blend_mul;
    logic       commit;
    logic [1:0] comp;
  } alvs_cmd_t;

  typedef struct packed {
    logic limit;
    logic root_done;
    logic div_done;
  } alvs_stat_t;
endpackage
`default_nettype wire

// File: src/alvs_ctrl.sv
// Controller sequencer of the velocity smoother.
// Depends on alvs_pkg for command and status types.
`default_nettype none
module alvs_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_fire,
  input  wire                  out_free,
  input  alvs_pkg::alvs_stat_t stat,
  output alvs_pkg::alvs_cmd_t  cmd,
  output logic                 busy,
  output logic                 out_set
);
  import alvs_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIFF  = 10'b0000000010,
    S_SQ    = 10'b0000000100,
    S_LIM   = 10'b0000001000,
    S_ROOT  = 10'b0000010000,
    S_DIVS  = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_BLEND = 10'b0010000000,
    S_COMM  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic vec, vec_next;
  logic [1:0] comp, comp_next;
  logic [1:0] sqc, sqc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vec <= 1'b0;
      comp <= 2'd0;
      sqc <= 2'd0;
    end else begin
      state <= state_next;
      vec <= vec_next;
      comp <= comp_next;
      sqc <= sqc_next;
    end
  end

  always_comb begin
    state_next = state;
    vec_next = vec;
    comp_next = comp;
    sqc_next = sqc;
    cmd = '0;
    cmd.vec_sel = vec;
    cmd.comp = comp;
    out_set = 1'b0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          vec_next = 1'b0;
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff = 1'b1;
        sqc_next = 2'd0;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq_start = 1'b1;
        cmd.comp = sqc;
        sqc_next = sqc + 2'd1;
        if (sqc == 2'd2) state_next = S_LIM;
      end
      S_LIM: begin
        cmd.lim_mul = 1'b1;
        cmd.root_start = 1'b1;
        comp_next = 2'd0;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (stat.root_done) state_next = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (!stat.limit || stat.div_done) state_next = S_BLEND;
      end
      S_BLEND: begin
        cmd.blend_mul = 1'b1;
        state_next = S_COMM;
      end
      S_COMM: begin
        cmd.commit = 1'b1;
        if (comp == 2'd2) begin
          comp_next = 2'd0;
          if (vec) state_next = S_OUT;
          else begin
            vec_next = 1'b1;
            state_next = S_DIFF;
          end
        end else begin
          comp_next = comp + 2'd1;
          state_next = S_DIVS;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_set = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: src/alvs_dp.sv
// Datapath of the velocity smoother: differences, sum of squares,
// bit-pair square root, restoring divider, blend and saturating update.
// Depends on alvs_pkg.
`default_nettype none
module alvs_dp (
  input  wire                       clk,
  input  wire                       rst,
  input  alvs_pkg::alvs_cmd_t       cmd,
  output alvs_pkg::alvs_stat_t      stat,
  input  wire [6*alvs_pkg::VW-1:0]  in_data,
  input  wire [alvs_pkg::LW-1:0]    max_lin,
  input  wire [alvs_pkg::LW-1:0]    max_ang,
  input  wire [16:0]                blend,
  input  wire [15:0]                period,
  output logic [6*alvs_pkg::VW-1:0] cur_flat
);
  import alvs_pkg::*;

  logic signed [VW-1:0] cmdv [6];
  logic signed [VW-1:0] cur [6];
  logic signed [DW-1:0] d [3];
  logic [VW:0] mag [3];
  logic [SW-1:0] ssum;
  logic [2*VW+1:0] sq;
  logic sq_v;
  logic [LW-1:0] lim;
  logic limit;
  logic [SW-1:0] rrad;
  logic [RW+1:0] rrem;
  logic [RW-1:0] root;
  logic [5:0] rcnt;
  logic [VW+LW:0] dquo;
  logic [VW+LW:0] drem;
  logic [6:0] dcnt;
  logic [VW:0] sres;
  logic signed [VW+17:0] tprod;
  logic [2:0] base;

  assign base = cmd.vec_sel ? 3'd3 : 3'd0;

  for (genvar g = 0; g < 6; g++) begin : g_flat
    assign cur_flat[g*VW +: VW] = cur[g];
  end

  // squares are taken straight from the difference register
  logic signed [DW-1:0] d_sel;
  logic [VW:0] mag_sel;
  assign d_sel = d[cmd.comp];
  assign mag_sel = d_sel[DW-1] ? (VW+1)'(-d_sel) : (VW+1)'(d_sel);

  logic [2*VW+1:0] trial_r;
  logic [RW+1:0] rem_sh;
  assign rem_sh = {rrem[RW-1:0], rrad[SW-1:SW-2]};
  assign trial_r = {{(2*VW+2-RW-2){1'b0}}, root, 2'b01};

  logic [VW+LW+1:0] drem_sh;
  assign drem_sh = {drem, dquo[VW+LW]};

  logic [LW+15:0] limp;
  assign limp = (cmd.vec_sel ? max_ang : max_lin) * period;

  logic signed [17:0] bfs;
  assign bfs = (blend > 17'd65536) ? 18'sd65536 : $signed({1'b0, blend});
  logic signed [VW+1:0] s_signed;
  assign s_signed = d[cmd.comp][DW-1] ? -$signed({1'b0, sres}) : $signed({1'b0, sres});

  logic signed [VW+17:0] qv;
  assign qv = (tprod + $signed((VW+18)'(1 << (FB-1)))) >>> FB;
  logic signed [VW+18:0] nsum;
  assign nsum = $signed({{19{cur[base+3'(cmd.comp)][VW-1]}}, cur[base+3'(cmd.comp)]}) +
                $signed({qv[VW+17], qv});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) cur[i] <= '0;
    end else if (cmd.commit) begin
      if (nsum > $signed({20'b0, {(VW-1){1'b1}}}))
        cur[base+3'(cmd.comp)] <= {1'b0, {(VW-1){1'b1}}};
      else if (nsum < -$signed({20'b0, {(VW-1){1'b1}}}) - 1)
        cur[base+3'(cmd.comp)] <= {1'b1, {(VW-1){1'b0}}};
      else
        cur[base+3'(cmd.comp)] <= nsum[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load)
      for (int i = 0; i < 6; i++) cmdv[i] <= in_data[i*VW +: VW];
    if (cmd.diff) begin
      for (int i = 0; i < 3; i++) begin
        d[i] <= $signed({cmdv[base+3'(i)][VW-1], cmdv[base+3'(i)]}) -
                $signed({cur[base+3'(i)][VW-1], cur[base+3'(i)]});
        mag[i] <= '0;
      end
      ssum <= '0;
      sq_v <= 1'b0;
    end else begin
      for (int i = 0; i < 3; i++)
        mag[i] <= d[i][DW-1] ? (VW+1)'(-d[i]) : (VW+1)'(d[i]);
    end
    if (cmd.sq_start) begin
      sq <= mag_sel * mag_sel;
      sq_v <= 1'b1;
    end
    if (sq_v && (cmd.sq_start || cmd.lim_mul)) ssum <= ssum + SW'(sq);
    if (cmd.lim_mul) begin
      sq_v <= 1'b0;
      lim <= limp[LW+15:16];
    end
    if (cmd.root_start) begin
      rrad <= ssum + SW'(sq);
      rrem <= '0;
      root <= '0;
      rcnt <= '0;
      limit <= 1'b0;
    end else if (cmd.root_step) begin
      if (rcnt == 6'd0) limit <= (rrad > SW'(lim) * SW'(lim));
      if (rcnt < 6'd33) begin
        rrad <= {rrad[SW-3:0], 2'b00};
        if ({{(2*VW+2-RW-2){1'b0}}, rem_sh} >= trial_r) begin
          rrem <= (RW+2)'({{(2*VW+2-RW-2){1'b0}}, rem_sh} - trial_r);
          root <= {root[RW-2:0], 1'b1};
        end else begin
          rrem <= rem_sh;
          root <= {root[RW-2:0], 1'b0};
        end
        rcnt <= rcnt + 6'd1;
      end
    end
    if (cmd.div_start) begin
      dquo <= mag[cmd.comp] * lim;
      drem <= '0;
      dcnt <= '0;
    end else if (cmd.div_step && dcnt < 7'(VW+LW+1)) begin
      if (drem_sh >= {{(VW+LW+2-RW){1'b0}}, root}) begin
        drem <= (VW+LW+1)'(drem_sh - {{(VW+LW+2-RW){1'b0}}, root});
        dquo <= {dquo[VW+LW-1:0], 1'b1};
      end else begin
        drem <= drem_sh[VW+LW:0];
        dquo <= {dquo[VW+LW-1:0], 1'b0};
      end
      dcnt <= dcnt + 7'd1;
    end
    if (cmd.div_step)
      sres <= (limit && root != '0) ? dquo[VW:0] : mag[cmd.comp];
    if (cmd.blend_mul) tprod <= (VW+18)'(s_signed * bfs);
  end

  assign stat.limit = limit && (root != '0);
  assign stat.root_done = (rcnt == 6'd33);
  assign stat.div_done = (dcnt == 7'(VW+LW+1));
endmodule
`default_nettype wire

// File: src/accel_limited_velocity_smoother.sv
// Acceleration-limited velocity smoother, top level.
// From input beat to result, per vector: differences, squares and the 33-step
// square root, then each component in turn, through the 64-step restoring divider
// when the step is limited; one item at a time, next input taken in the cycle
// after the result is loaded.
// Result is held in an output register until taken.
// Synchronous reset clears velocities to zero and registers to defaults.
// Depends on alvs_pkg, alvs_ctrl, alvs_dp.
`default_nettype none
module accel_limited_velocity_smoother (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  // lin_cmd_x, lin_cmd_y, lin_cmd_z, ang_cmd_x, ang_cmd_y, ang_cmd_z
  input  wire [191:0]  s_tdata,
  output logic         m_tvalid,
  input  wire          m_tready,
  // lin_out_x, lin_out_y, lin_out_z, ang_out_x, ang_out_y, ang_out_z
  output logic [191:0] m_tdata,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire [1:0]    cfg_index,
  input  wire [31:0]   cfg_data
);
  import alvs_pkg::*;

  alvs_cmd_t cmd;
  alvs_stat_t stat;
  logic busy, out_set;
  logic [30:0] max_lin, max_ang;
  logic [16:0] blend;
  logic [15:0] period;
  logic [191:0] cur_flat;

  assign s_tready = !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_lin <= 31'd131072;
      max_ang <= 31'd262144;
      blend <= 17'd52429;
      period <= 16'd2185;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_LIN: max_lin <= cfg_data[30:0];
        REG_MAX_ANG: max_ang <= cfg_data[30:0];
        REG_BLEND: blend <= cfg_data[16:0];
        REG_PERIOD: period <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_set) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
    if (out_set) m_tdata <= cur_flat;
  end

  alvs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(s_tvalid && s_tready),
    .out_free(!m_tvalid || m_tready), .stat(stat), .cmd(cmd),
    .busy(busy), .out_set(out_set)
  );

  alvs_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_data(s_tdata),
    .max_lin(max_lin), .max_ang(max_ang), .blend(blend), .period(period),
    .cur_flat(cur_flat)
  );
endmodule
`default_nettype wire
